[rtl/assert_macros.svh]
// Shared assertion macros for the lock-order detector checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define LOCD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("locd check failed");

// Clocked check that also holds during reset.
`define LOCD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("locd check failed");

`endif

[rtl/locd_pkg.sv]
package locd_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_THREADS = 8;
    localparam int DEF_MAX_HELD    = 16;
    localparam int DEF_ADDR_BITS   = 48;

    localparam int OP_W     = 2;
    localparam int TID_W    = 3;
    localparam int MADDR_W  = 48;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCK     = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEADLOCK   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HALTED     = 3'd5;

    typedef struct packed {
        logic                capture;
        logic                set_st;
        logic [STATUS_W-1:0] st;
        logic                scan_init;
        logic                key_held;
        logic                scan_rd;
        logic                scan_next;
        logic                save_to;
        logic                save_from;
        logic                node_wr;
        logic                held_rd_last;
        logic                walk_init;
        logic                walk_pick;
        logic                walk_merge;
        logic                edge_rd_from;
        logic                edge_wr_bit;
        logic                push;
        logic                unl_init;
        logic                unl_rd;
        logic                unl_step;
        logic                unl_done;
        logic                finish;
    } locd_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tid_ok;
        logic            halted;
        logic            depth_zero;
        logic            depth_full;
        logic            scan_end;
        logic            scan_hit;
        logic            table_full;
        logic            same_node;
        logic            pend_empty;
        logic            target_hit;
        logic            unl_end;
        logic            out_busy;
    } locd_stat_t;

endpackage

[rtl/lock_order_cycle_detector_core.sv]
// One item is handled at a time; the address table scan, one entry at a time, and the
// reachability walk, one matrix row at a time, set the rate.
// Reset: asynchronous, active low; clears counts, held depths, halt and output valid.
// Memories are not cleared; rows are zeroed as nodes are registered.
module lock_order_cycle_detector_core
    import locd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_THREADS = DEF_MAX_THREADS,
    parameter int MAX_HELD    = DEF_MAX_HELD,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // op[1:0], thread_id[4:2], mutex_addr[52:5]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // status[2:0], node_total[9:3]
);

    locd_cmd_t           cmd;
    locd_stat_t          stat;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  node_total;

    locd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    locd_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_THREADS (MAX_THREADS),
        .MAX_HELD    (MAX_HELD),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_in      (s_axis_tdata[1:0]),
        .tid_in     (s_axis_tdata[4:2]),
        .addr_in    (s_axis_tdata[52:5]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_total  (node_total)
    );

    assign m_axis_tdata = {(M_DATA_W - STATUS_W - TOTAL_W)'(0), node_total, status};

endmodule

[rtl/locd_ctrl.sv]
module locd_ctrl
    import locd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  locd_stat_t stat,
    output locd_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_DISPATCH   = 14'b00000000000010,
        S_SCAN_RD    = 14'b00000000000100,
        S_SCAN_CMP   = 14'b00000000001000,
        S_HELD_WAIT  = 14'b00000000010000,
        S_WALK_INIT  = 14'b00000000100000,
        S_WALK_PICK  = 14'b00000001000000,
        S_WALK_MERGE = 14'b00000010000000,
        S_EDGE_RD    = 14'b00000100000000,
        S_EDGE_WR    = 14'b00001000000000,
        S_PUSH       = 14'b00010000000000,
        S_UNL_RD     = 14'b00100000000000,
        S_UNL_CMP    = 14'b01000000000000,
        S_FINISH     = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_REG  = 2'd0,
        PH_TO   = 2'd1,
        PH_FROM = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_REG;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.st     = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.set_st = 1'b1;
                state_next = S_FINISH;
                if (stat.halted)
                begin
                    cmd.st = ST_HALTED;
                end
                else if (stat.op == OP_REGISTER)
                begin
                    cmd.scan_init = 1'b1;
                    phase_next    = PH_REG;
                    state_next    = S_SCAN_RD;
                end
                else if (stat.op == OP_LOCK && stat.tid_ok)
                begin
                    if (stat.depth_full)
                    begin
                        cmd.st = ST_STACK_FULL;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        phase_next    = PH_TO;
                        state_next    = S_SCAN_RD;
                    end
                end
                else if (stat.op == OP_UNLOCK && stat.tid_ok)
                begin
                    cmd.unl_init = 1'b1;
                    state_next   = S_UNL_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    // address not registered
                    if (phase_reg == PH_REG)
                    begin
                        if (stat.table_full)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = ST_TABLE_FULL;
                        end
                        else
                        begin
                            cmd.node_wr = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_UNKNOWN;
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.scan_hit)
                begin
                    if (phase_reg == PH_REG)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (phase_reg == PH_TO)
                    begin
                        cmd.save_to = 1'b1;
                        if (stat.depth_zero)
                        begin
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            cmd.held_rd_last = 1'b1;
                            state_next       = S_HELD_WAIT;
                        end
                    end
                    else
                    begin
                        cmd.save_from = 1'b1;
                        state_next    = S_WALK_INIT;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_HELD_WAIT:
            begin
                cmd.scan_init = 1'b1;
                cmd.key_held  = 1'b1;
                phase_next    = PH_FROM;
                state_next    = S_SCAN_RD;
            end
            S_WALK_INIT:
            begin
                if (stat.same_node)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_DEADLOCK;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK_PICK;
                end
            end
            S_WALK_PICK:
            begin
                if (stat.pend_empty)
                begin
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    cmd.walk_pick = 1'b1;
                    state_next    = S_WALK_MERGE;
                end
            end
            S_WALK_MERGE:
            begin
                cmd.walk_merge = 1'b1;
                if (stat.target_hit)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_DEADLOCK;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    state_next = S_WALK_PICK;
                end
            end
            S_EDGE_RD:
            begin
                cmd.edge_rd_from = 1'b1;
                state_next       = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                cmd.edge_wr_bit = 1'b1;
                state_next      = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_FINISH;
            end
            S_UNL_RD:
            begin
                if (stat.unl_end)
                begin
                    cmd.unl_done = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.unl_rd = 1'b1;
                    state_next = S_UNL_CMP;
                end
            end
            S_UNL_CMP:
            begin
                cmd.unl_step = 1'b1;
                state_next   = S_UNL_RD;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/locd_dp.sv]
module locd_dp
    import locd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_THREADS = DEF_MAX_THREADS,
    parameter int MAX_HELD    = DEF_MAX_HELD,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     op_in,
    input  logic [TID_W-1:0]    tid_in,
    input  logic [MADDR_W-1:0]  addr_in,
    input  locd_cmd_t           cmd,
    output locd_stat_t          stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [TOTAL_W-1:0]  out_total
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int DW  = $clog2(MAX_HELD + 1);
    localparam int TW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int HD  = MAX_THREADS * MAX_HELD;
    localparam int HAW = $clog2(HD);
    localparam logic [MAX_NODES-1:0] ONE_N = MAX_NODES'(1);

    logic [OP_W-1:0]      op_reg;
    logic [TID_W-1:0]     tid_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] key_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic [CW-1:0]        idx_reg;
    logic [NW-1:0]        to_reg;
    logic [NW-1:0]        from_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [MAX_NODES-1:0] pend_reg;
    logic [DW-1:0]        rd_reg;
    logic [DW-1:0]        wr_reg;

    logic                 halted_reg, halted_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [DW-1:0]        depth_reg [MAX_THREADS];
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic [ADDR_BITS-1:0] node_mem [MAX_NODES];
    logic [ADDR_BITS-1:0] node_rdata_reg;
    logic [MAX_NODES-1:0] edge_mem [MAX_NODES];
    logic [MAX_NODES-1:0] edge_rdata_reg;
    logic [ADDR_BITS-1:0] held_mem [HD];
    logic [ADDR_BITS-1:0] held_rdata_reg;

    logic                 tid_ok;
    logic [TW-1:0]        tid_idx;
    logic [DW-1:0]        cur_depth;
    logic [NW-1:0]        pick_idx;
    logic [NW-1:0]        edge_raddr;
    logic [HAW-1:0]       held_raddr;

    function automatic logic [HAW-1:0] held_at(input logic [TW-1:0] t, input logic [DW-1:0] i);
        held_at = HAW'(t) * HAW'(MAX_HELD) + HAW'(i);
    endfunction

    assign tid_ok    = (32'(tid_reg) < MAX_THREADS);
    assign tid_idx   = TW'(tid_reg);
    assign cur_depth = tid_ok ? depth_reg[tid_idx] : '0;

    // lowest pending node is walked next
    always_comb
    begin
        pick_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick_idx = NW'(i);
            end
        end
    end

    assign edge_raddr = cmd.edge_rd_from ? from_reg : pick_idx;
    assign held_raddr = cmd.held_rd_last ? held_at(tid_idx, cur_depth - DW'(1))
                                         : held_at(tid_idx, rd_reg);

    always_comb
    begin
        stat.op         = op_reg;
        stat.tid_ok     = tid_ok;
        stat.halted     = halted_reg;
        stat.depth_zero = (cur_depth == '0);
        stat.depth_full = (cur_depth >= DW'(MAX_HELD));
        stat.scan_end   = (idx_reg == count_reg);
        stat.scan_hit   = (node_rdata_reg == key_reg);
        stat.table_full = (count_reg >= CW'(MAX_NODES));
        stat.same_node  = (to_reg == from_reg);
        stat.pend_empty = (pend_reg == '0);
        stat.target_hit = edge_rdata_reg[from_reg];
        stat.unl_end    = (rd_reg == cur_depth);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        halted_next = halted_reg;
        count_next  = count_reg;
        if (cmd.finish && st_reg == ST_DEADLOCK)
        begin
            halted_next = 1'b1;
        end
        if (cmd.node_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < MAX_THREADS; t++)
            begin
                depth_reg[t] <= '0;
            end
        end
        else
        begin
            halted_reg    <= halted_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.push)
            begin
                depth_reg[tid_idx] <= cur_depth + DW'(1);
            end
            else if (cmd.unl_done)
            begin
                depth_reg[tid_idx] <= wr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_in;
            tid_reg  <= tid_in;
            addr_reg <= ADDR_BITS'(addr_in);
        end
        if (cmd.set_st)
        begin
            st_reg <= cmd.st;
        end
        if (cmd.scan_init)
        begin
            idx_reg <= '0;
            key_reg <= cmd.key_held ? held_rdata_reg : addr_reg;
        end
        else if (cmd.scan_next)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.save_to)
        begin
            to_reg <= idx_reg[NW-1:0];
        end
        if (cmd.save_from)
        begin
            from_reg <= idx_reg[NW-1:0];
        end
        if (cmd.walk_init)
        begin
            visited_reg <= ONE_N << to_reg;
            pend_reg    <= ONE_N << to_reg;
        end
        else if (cmd.walk_pick)
        begin
            pend_reg[pick_idx] <= 1'b0;
        end
        else if (cmd.walk_merge)
        begin
            visited_reg <= visited_reg | edge_rdata_reg;
            pend_reg    <= pend_reg | (edge_rdata_reg & ~visited_reg);
        end
        if (cmd.unl_init)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else if (cmd.unl_step)
        begin
            rd_reg <= rd_reg + DW'(1);
            if (held_rdata_reg != addr_reg)
            begin
                wr_reg <= wr_reg + DW'(1);
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= st_reg;
            out_total_reg  <= TOTAL_W'(count_reg);
        end
    end

    // mutex address table
    always_ff @(posedge clk)
    begin
        if (cmd.node_wr)
        begin
            node_mem[count_reg[NW-1:0]] <= addr_reg;
        end
        if (cmd.scan_rd)
        begin
            node_rdata_reg <= node_mem[idx_reg[NW-1:0]];
        end
    end

    // lock-order matrix, one row per node
    always_ff @(posedge clk)
    begin
        if (cmd.node_wr)
        begin
            edge_mem[count_reg[NW-1:0]] <= '0;
        end
        else if (cmd.edge_wr_bit)
        begin
            edge_mem[from_reg] <= edge_rdata_reg | (ONE_N << to_reg);
        end
        if (cmd.walk_pick || cmd.edge_rd_from)
        begin
            edge_rdata_reg <= edge_mem[edge_raddr];
        end
    end

    // per-thread held lists
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            held_mem[held_at(tid_idx, cur_depth)] <= addr_reg;
        end
        else if (cmd.unl_step && held_rdata_reg != addr_reg)
        begin
            held_mem[held_at(tid_idx, wr_reg)] <= held_rdata_reg;
        end
        if (cmd.held_rd_last || cmd.unl_rd)
        begin
            held_rdata_reg <= held_mem[held_raddr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_total  = out_total_reg;

endmodule

[rtl/locd_chk.sv]
`include "assert_macros.svh"

module locd_chk
    import locd_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int FULL_TOTAL = MAX_NODES % 128;

    logic [STATUS_W-1:0] st;
    logic [TOTAL_W-1:0]  total;
    logic                stall;
    logic                full_out;

    assign st       = m_axis_tdata[2:0];
    assign total    = m_axis_tdata[9:3];
    assign stall    = m_axis_tvalid && !m_axis_tready;
    assign full_out = m_axis_tvalid && st == ST_TABLE_FULL;

    `LOCD_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |-> !m_axis_tvalid)
    `LOCD_ASSERT(a_hold, clk, rst_n, stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    `LOCD_ASSERT(a_full_total, clk, rst_n, full_out |-> 32'(total) == FULL_TOTAL)
    `LOCD_ASSERT(a_total_range, clk, rst_n, m_axis_tvalid && MAX_NODES < 128 |-> 32'(total) <= MAX_NODES)

endmodule

bind lock_order_cycle_detector_core locd_chk #(.MAX_NODES(MAX_NODES)) u_locd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_lock_order_cycle_detector_core.sv]
`timescale 1ns / 1ps

module tb_lock_order_cycle_detector_core;
    import locd_pkg::*;

    localparam int NODES   = DEF_MAX_NODES;
    localparam int THREADS = DEF_MAX_THREADS;
    localparam int HELD    = DEF_MAX_HELD;
    localparam int N_RAND  = 1450;
    localparam int HOLD_START = 3000;
    localparam int HOLD_END   = 5200;
    localparam int CALM_START = 30000;
    localparam int CALM_END   = 60000;

    localparam logic [OP_W-1:0] OP_BAD = 2'd3;

    typedef logic [MADDR_W-1:0] addr_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } verdict_t;

    class lock_graph_scoreboard;
        addr_t      node_addr[NODES];
        int         node_cnt;
        bit [NODES-1:0] edges[NODES];
        addr_t      held[THREADS][HELD];
        int         depth[THREADS];
        bit         halted;
        verdict_t   pending_q[$];
        int         mismatches;
        int         checked;
        int         deadlocks;

        function int find_node(addr_t a);
            for (int i = 0; i < node_cnt; i++)
                if (node_addr[i] == a)
                    return i;
            return -1;
        endfunction

        function bit [NODES-1:0] reach_set(int start);
            bit [NODES-1:0] r;
            bit [NODES-1:0] prev;
            r = '0;
            r[start] = 1'b1;
            do
            begin
                prev = r;
                for (int i = 0; i < NODES; i++)
                    if (r[i])
                        r |= edges[i];
            end
            while (r != prev);
            return r;
        endfunction

        // True when this lock would close a lock-order cycle.
        function bit closes_cycle(int tid, addr_t a);
            int to_n;
            int from_n;
            bit [NODES-1:0] r;
            if (halted || depth[tid] == 0 || depth[tid] >= HELD)
                return 0;
            to_n = find_node(a);
            from_n = find_node(held[tid][depth[tid]-1]);
            if (to_n < 0 || from_n < 0)
                return 0;
            r = reach_set(to_n);
            return r[from_n];
        endfunction

        function void note_input(logic [OP_W-1:0] op, int tid, addr_t a);
            verdict_t v;
            int to_n;
            int from_n;
            int w;
            bit [NODES-1:0] r;
            v.status = ST_OK;
            if (halted)
                v.status = ST_HALTED;
            else if (op == OP_REGISTER)
            begin
                if (find_node(a) < 0)
                begin
                    if (node_cnt >= NODES)
                        v.status = ST_TABLE_FULL;
                    else
                    begin
                        node_addr[node_cnt] = a;
                        edges[node_cnt] = '0;
                        node_cnt++;
                    end
                end
            end
            else if (op == OP_LOCK)
            begin
                if (depth[tid] >= HELD)
                    v.status = ST_STACK_FULL;
                else
                begin
                    to_n = find_node(a);
                    if (to_n < 0)
                        v.status = ST_UNKNOWN;
                    else if (depth[tid] > 0)
                    begin
                        from_n = find_node(held[tid][depth[tid]-1]);
                        if (from_n < 0)
                            v.status = ST_UNKNOWN;
                        else
                        begin
                            edges[from_n][to_n] = 1'b1;
                            r = reach_set(to_n);
                            if (r[from_n])
                            begin
                                v.status = ST_DEADLOCK;
                                halted = 1'b1;
                                deadlocks++;
                            end
                        end
                    end
                    held[tid][depth[tid]] = a;
                    depth[tid]++;
                end
            end
            else if (op == OP_UNLOCK)
            begin
                w = 0;
                for (int i = 0; i < depth[tid]; i++)
                    if (held[tid][i] != a)
                    begin
                        held[tid][w] = held[tid][i];
                        w++;
                    end
                depth[tid] = w;
            end
            v.total = node_cnt[TOTAL_W-1:0];
            pending_q = {pending_q, v};
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [TOTAL_W-1:0] tot);
            verdict_t v;
            checked++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d total=%0d", st, tot);
                return;
            end
            v = pending_q.pop_front();
            if (st !== v.status || tot !== v.total)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: status exp %0d got %0d, total exp %0d got %0d",
                             checked, v.status, st, v.total, tot);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    lock_graph_scoreboard sb;
    int    cyc;
    addr_t pool[72];

    lock_order_cycle_detector_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("ERROR: timeout");
        $display("tb_lock_order_cycle_detector_core failed");
        $finish;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    function automatic bit calm();
        return cyc >= CALM_START && cyc < CALM_END;
    endfunction

    // Receiver: random stalls, one long hold-off, one stretch always ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cyc >= HOLD_START && cyc < HOLD_END)
            m_axis_tready <= 1'b0;
        else if (calm())
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 14);
    end

    // Sample at the falling edge, act at the next rising edge.
    logic                out_fire;
    logic [M_DATA_W-1:0] out_data;
    always @(negedge clk)
    begin
        out_fire <= m_axis_tvalid && m_axis_tready && rst_n;
        out_data <= m_axis_tdata;
    end
    always @(posedge clk)
        if (out_fire)
            sb.check_result(out_data[2:0], out_data[9:3]);

    task automatic send(logic [OP_W-1:0] op, int tid, addr_t a);
        bit ok;
        while (!calm() && $urandom_range(99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, a, tid[TID_W-1:0], op};
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        sb.note_input(op, tid, a);
    endtask

    function automatic addr_t rand_addr();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    task automatic send_random();
        int    r;
        int    tid;
        addr_t a;
        r = $urandom_range(99);
        tid = $urandom_range(THREADS-1);
        if (r < 12)
            send(OP_REGISTER, tid, pool[$urandom_range(71)]);
        else if (r < 15)
            send(OP_BAD, tid, rand_addr());
        else if (r < 60)
        begin
            a = ($urandom_range(99) < 85) ? pool[$urandom_range(71)] : rand_addr();
            // steer away from a cycle so the halt comes only at the end
            if (sb.closes_cycle(tid, a))
                send(OP_UNLOCK, tid, sb.held[tid][sb.depth[tid]-1]);
            else
                send(OP_LOCK, tid, a);
        end
        else
        begin
            if (sb.depth[tid] > 0 && $urandom_range(99) < 75)
                a = sb.held[tid][$urandom_range(sb.depth[tid]-1)];
            else
                a = pool[$urandom_range(71)];
            send(OP_UNLOCK, tid, a);
        end
    endtask

    initial
    begin
        int    tid;
        int    waited;
        addr_t a;
        bit    done;
        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n = 1'b0;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 72; i++)
            pool[i] = rand_addr();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_REGISTER, 0, pool[0]);
        send(OP_REGISTER, 7, pool[1]);
        send(OP_REGISTER, 3, pool[2]);
        send(OP_REGISTER, 1, pool[0]);
        send(OP_BAD, 5, pool[1]);
        send(OP_LOCK, 0, 48'h5A5A_0000_0001);
        send(OP_LOCK, 0, pool[0]);
        send(OP_UNLOCK, 0, 48'h5A5A_0000_0001);
        send(OP_LOCK, 0, pool[1]);
        send(OP_LOCK, 2, pool[1]);
        send(OP_LOCK, 2, pool[2]);
        send(OP_UNLOCK, 0, pool[0]);
        send(OP_UNLOCK, 0, pool[1]);
        send(OP_UNLOCK, 2, 48'h1234_5678_9ABC);
        for (int i = 0; i < HELD + 1; i++)
            send(OP_LOCK, 7, 48'hDEAD_0000_BEEF);
        send(OP_UNLOCK, 7, 48'hDEAD_0000_BEEF);
        send(OP_UNLOCK, 2, pool[2]);
        send(OP_UNLOCK, 2, pool[1]);

        for (int n = 0; n < N_RAND; n++)
            send_random();

        // Close the run with a deadlock: a real cycle if one is at hand, else a self loop.
        done = 0;
        if ($urandom_range(1))
            for (int k = 0; k < 400 && !done; k++)
            begin
                tid = $urandom_range(THREADS-1);
                a = pool[$urandom_range(71)];
                if (sb.closes_cycle(tid, a) && sb.depth[tid] > 0 &&
                    sb.held[tid][sb.depth[tid]-1] != a)
                begin
                    send(OP_LOCK, tid, a);
                    done = 1;
                end
            end
        if (!done)
        begin
            if (sb.depth[0] >= HELD)
                send(OP_UNLOCK, 0, sb.held[0][HELD-1]);
            send(OP_LOCK, 0, pool[0]);
            send(OP_LOCK, 0, pool[0]);
        end
        send(OP_REGISTER, 4, rand_addr());
        send(OP_LOCK, 1, pool[0]);
        send(OP_UNLOCK, 6, pool[1]);
        send(OP_BAD, 3, pool[2]);
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (1000) @(posedge clk);
        if (sb.pending_q.size() != 0)
        begin
            sb.mismatches++;
            $display("ERROR: %0d results never arrived", sb.pending_q.size());
        end
        $display("Checked %0d results; %0d mutexes registered, %0d deadlock(s) seen.",
                 sb.checked, sb.node_cnt, sb.deadlocks);
        $display("Covered register, lock, unlock, odd ops, full tables and stacks, halt.");
        if (sb.mismatches == 0)
            $display("tb_lock_order_cycle_detector_core passed");
        else
            $display("tb_lock_order_cycle_detector_core failed");
        $finish;
    end

endmodule
